// ===== src/wprd_pkg.sv =====
// ----------------------------------------------------------------------------
// wprd_pkg
// Shared types and constants of the waveform peak/RMS decimator: field
// widths, register indexes, state encodings and inter-module structs.
// ----------------------------------------------------------------------------
package wprd_pkg;

   // Field and datapath widths.
   localparam int SAMPLE_W   = 16;                 // one Q1.15 sample
   localparam int SQ_W       = 2 * SAMPLE_W - 1;   // square of one sample
   localparam int SUMSQ_W    = 55;                 // saturating sum of squares
   localparam int TOTAL_W    = 24;                 // total_samples register
   localparam int COLS_W     = 13;                 // columns register
   localparam int COLUMN_W   = 12;                 // column output field
   localparam int COUNT_W    = 16;                 // internal column counter
   localparam int POS_W      = 37;                 // scaled positions
   localparam int PROD_W     = SUMSQ_W + COLS_W;   // sumsq * columns
   localparam int MEAN_W     = 2 * SAMPLE_W - 2;   // mean square below full scale
   localparam int ROOT_W     = SAMPLE_W - 1;       // root below full scale
   localparam int REM_W      = TOTAL_W + 1;        // divider partial remainder
   localparam int SQREM_W    = ROOT_W + 2;         // square root remainder
   localparam int CNT_W      = 5;                  // iteration counter
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 64;

   localparam int MAX_COLUMNS   = 4096;
   localparam int TOTAL_RESET   = 1024;
   localparam int COLUMNS_RESET = 1024;

   localparam logic [SAMPLE_W-1:0] RMS_FULL = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic [SUMSQ_W-1:0]  SUMSQ_MAX = {SUMSQ_W{1'b1}};

   // Register indexes, decoded from the word address.
   localparam logic REG_TOTAL_SAMPLES = 1'b0;
   localparam logic REG_COLUMNS       = 1'b1;

   // Iteration counts of the shared unit, counted down to zero.
   localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(COLS_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(MEAN_W - 1);
   localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);

   // Top level sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_CALC,
      ST_EMIT
   } dec_state_type;

   // Shared arithmetic unit states.
   typedef enum logic [2:0] {
      U_IDLE,
      U_MUL,
      U_SAT,
      U_DIV,
      U_SQRT,
      U_DONE
   } rms_state_type;

   // Control from the sequencer to the column statistics.
   typedef struct packed {
      logic accept;   // a sample transaction completes this cycle
      logic start;    // that sample opens a new waveform
      logic update;   // fold the captured sample into the column
   } stats_ctrl_type;

   // Status from the column statistics.
   typedef struct packed {
      logic                 emit;    // the sample closes a column
      logic [SUMSQ_W-1:0]   sumsq;   // sum of squares of that column
   } stats_stat_type;

   // Finished column, held until it is sent.
   typedef struct packed {
      logic [COLUMN_W-1:0]        column;
      logic signed [SAMPLE_W-1:0] min_level;
      logic signed [SAMPLE_W-1:0] max_level;
      logic                       last;
   } col_result_type;

   // Request to the shared RMS unit.
   typedef struct packed {
      logic               start;
      logic [SUMSQ_W-1:0] sumsq;
      logic [TOTAL_W-1:0] n;
      logic [COLS_W-1:0]  w;
   } rms_req_type;

   // Answer of the shared RMS unit.
   typedef struct packed {
      logic                done;
      logic [SAMPLE_W-1:0] rms;
   } rms_rsp_type;

endpackage

// ===== src/wprd_stats.sv =====
// ----------------------------------------------------------------------------
// wprd_stats
// Per-sample column tracking: scaled position and boundary, running
// minimum, maximum and saturating sum of squares, column counter.
// ----------------------------------------------------------------------------
module wprd_stats (
   input  logic                           clock,
   input  logic                           reset,
   input  wprd_pkg::stats_ctrl_type       ctrl,
   input  logic [wprd_pkg::SAMPLE_W-1:0]  sample,
   input  logic [wprd_pkg::TOTAL_W-1:0]   n_eff,
   input  logic [wprd_pkg::COLS_W-1:0]    w_eff,
   output wprd_pkg::stats_stat_type       stat,
   output wprd_pkg::col_result_type       result
);
   import wprd_pkg::*;

   logic [COUNT_W-1:0]         col_ff, col_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [POS_W-1:0]           bound_ff, bound_in;
   logic signed [SAMPLE_W-1:0] min_ff, min_in;
   logic signed [SAMPLE_W-1:0] max_ff, max_in;
   logic [SUMSQ_W-1:0]         sum_ff, sum_in;
   logic                       open_ff, open_in;

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [SQ_W-1:0]            sq_ff;
   logic [POS_W-1:0]           limit_ff;
   col_result_type             result_ff;

   logic signed [2*SAMPLE_W-1:0] sq_full;
   logic [POS_W-1:0]             limit_prod;
   logic [POS_W-1:0]             next_pos;
   logic                         active;
   logic                         hit;
   logic [SUMSQ_W:0]             sum_wide;
   logic signed [SAMPLE_W-1:0]   upd_min;
   logic signed [SAMPLE_W-1:0]   upd_max;
   logic [SUMSQ_W-1:0]           upd_sum;
   logic                         is_last;

   // Square and position limit are taken when the sample arrives.
   assign sq_full    = $signed(sample) * $signed(sample);
   assign limit_prod = POS_W'(w_eff) * POS_W'(n_eff);

   // Column arithmetic on the captured sample.
   always_comb begin
      active   = pos_ff < limit_ff;
      next_pos = pos_ff + POS_W'(w_eff);
      hit      = next_pos >= bound_ff;
      sum_wide = {1'b0, sum_ff} + (SUMSQ_W + 1)'(sq_ff);
      if (open_ff) begin
         upd_min = (sample_ff < min_ff) ? sample_ff : min_ff;
         upd_max = (sample_ff > max_ff) ? sample_ff : max_ff;
         upd_sum = sum_wide[SUMSQ_W] ? SUMSQ_MAX : sum_wide[SUMSQ_W-1:0];
      end else begin
         upd_min = sample_ff;
         upd_max = sample_ff;
         upd_sum = SUMSQ_W'(sq_ff);
      end
      is_last = col_ff == (COUNT_W'(w_eff) - COUNT_W'(1));
   end

   // Next state of the column tracker.
   always_comb begin
      col_in   = col_ff;
      pos_in   = pos_ff;
      bound_in = bound_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      sum_in   = sum_ff;
      open_in  = open_ff;
      if (ctrl.accept && ctrl.start) begin
         col_in   = '0;
         pos_in   = '0;
         bound_in = POS_W'(n_eff);
         open_in  = 1'b0;
      end
      if (ctrl.update && active) begin
         pos_in = next_pos;
         if (!hit) begin
            min_in  = upd_min;
            max_in  = upd_max;
            sum_in  = upd_sum;
            open_in = 1'b1;
         end else begin
            col_in   = col_ff + COUNT_W'(1);
            bound_in = bound_ff + POS_W'(n_eff);
            // A sample that straddles the boundary also opens the next column.
            if (next_pos > bound_ff) begin
               min_in  = sample_ff;
               max_in  = sample_ff;
               sum_in  = SUMSQ_W'(sq_ff);
               open_in = 1'b1;
            end else begin
               open_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         pos_ff   <= '0;
         bound_ff <= POS_W'(TOTAL_RESET);
         min_ff   <= '0;
         max_ff   <= '0;
         sum_ff   <= '0;
         open_ff  <= 1'b0;
      end else begin
         col_ff   <= col_in;
         pos_ff   <= pos_in;
         bound_ff <= bound_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         sum_ff   <= sum_in;
         open_ff  <= open_in;
      end
   end

   // Sample capture and finished column snapshot.
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         sample_ff <= $signed(sample);
         sq_ff     <= sq_full[SQ_W-1:0];
         limit_ff  <= limit_prod;
      end
      if (stat.emit) begin
         result_ff.column    <= col_ff[COLUMN_W-1:0];
         result_ff.min_level <= upd_min;
         result_ff.max_level <= upd_max;
         result_ff.last      <= is_last;
      end
   end

   assign stat.emit  = ctrl.update && active && hit;
   assign stat.sumsq = upd_sum;
   assign result     = result_ff;

endmodule

// ===== src/wprd_rms_unit.sv =====
// ----------------------------------------------------------------------------
// wprd_rms_unit
// Shared iterative unit for the column RMS: shift-add multiply by the
// column count, restoring divide by the sample count, then a digit-by-digit
// square root, all on one adder/subtractor.
// ----------------------------------------------------------------------------
module wprd_rms_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  wprd_pkg::rms_req_type req,
   output wprd_pkg::rms_rsp_type rsp
);
   import wprd_pkg::*;

   rms_state_type       state_ff, state_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic [PROD_W-1:0]   mcand_ff, mcand_in;
   logic [COLS_W-1:0]   mplier_ff, mplier_in;
   logic [TOTAL_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [MEAN_W-1:0]   quo_ff, quo_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [SAMPLE_W-1:0] rms_ff, rms_in;

   logic [PROD_W-1:0]   alu_a;
   logic [PROD_W-1:0]   alu_b;
   logic                alu_sub;
   logic [PROD_W:0]     alu_res;
   logic                carry;
   logic                done;
   logic [ROOT_W-1:0]   root_next;

   // The shared adder; on subtract the carry out means a >= b.
   assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                    + (PROD_W + 1)'(alu_sub);
   assign carry   = alu_res[PROD_W];

   // Square root digit, one root bit a step.
   assign root_next = {root_ff[ROOT_W-2:0], carry};

   // Operand selection for the shared adder, from the registers only.
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         U_MUL: begin
            alu_a = acc_ff;
            alu_b = mplier_ff[0] ? mcand_ff : '0;
         end
         U_SAT: begin
            alu_a   = PROD_W'(acc_ff[PROD_W-1:MEAN_W]);
            alu_b   = PROD_W'(n_ff);
            alu_sub = 1'b1;
         end
         U_DIV: begin
            alu_a   = PROD_W'({rem_ff[TOTAL_W-1:0], quo_ff[MEAN_W-1]});
            alu_b   = PROD_W'(n_ff);
            alu_sub = 1'b1;
         end
         U_SQRT: begin
            alu_a   = PROD_W'({rem_ff[SQREM_W-1:0], quo_ff[MEAN_W-1:MEAN_W-2]});
            alu_b   = PROD_W'({root_ff, 2'b01});
            alu_sub = 1'b1;
         end
         default: begin
            alu_sub = 1'b0;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      n_in      = n_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      root_in   = root_ff;
      rms_in    = rms_ff;
      done      = 1'b0;
      case (state_ff)
         U_IDLE: begin
            if (req.start) begin
               acc_in    = '0;
               mcand_in  = PROD_W'(req.sumsq);
               mplier_in = req.w;
               n_in      = req.n;
               cnt_in    = MUL_LAST;
               state_in  = U_MUL;
            end
         end
         U_MUL: begin
            // One multiplier bit a cycle.
            acc_in    = alu_res[PROD_W-1:0];
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            if (cnt_ff == '0) begin
               state_in = U_SAT;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         U_SAT: begin
            // Quotient at or above full scale squared saturates the RMS.
            if (carry) begin
               rms_in   = RMS_FULL;
               state_in = U_DONE;
            end else begin
               rem_in   = REM_W'(acc_ff[MEAN_W+TOTAL_W-1:MEAN_W]);
               quo_in   = acc_ff[MEAN_W-1:0];
               cnt_in   = DIV_LAST;
               state_in = U_DIV;
            end
         end
         U_DIV: begin
            // Restoring divide: dividend bits shift out as quotient bits shift in.
            quo_in  = {quo_ff[MEAN_W-2:0], carry};
            rem_in  = carry ? alu_res[REM_W-1:0] : {rem_ff[TOTAL_W-1:0], quo_ff[MEAN_W-1]};
            if (cnt_ff == '0) begin
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = SQRT_LAST;
               state_in = U_SQRT;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         U_SQRT: begin
            // Two radicand bits a cycle, trial value is root followed by 01.
            root_in = root_next;
            rem_in  = carry ? REM_W'(alu_res[SQREM_W+1:0])
                            : REM_W'({rem_ff[SQREM_W-1:0], quo_ff[MEAN_W-1:MEAN_W-2]});
            quo_in  = quo_ff << 2;
            if (cnt_ff == '0) begin
               rms_in   = {1'b0, root_next};
               state_in = U_DONE;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         U_DONE: begin
            done     = 1'b1;
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      n_ff      <= n_in;
      cnt_ff    <= cnt_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      root_ff   <= root_in;
      rms_ff    <= rms_in;
   end

   assign rsp.done = done;
   assign rsp.rms  = rms_ff;

endmodule

// ===== src/waveform_peak_rms_decimator.sv =====
// ----------------------------------------------------------------------------
// waveform_peak_rms_decimator
// Splits a stream of samples into display columns and reports
// each column's minimum, maximum and RMS.
// ----------------------------------------------------------------------------
// Usage:
//   Program total_samples and columns over the csr_ port, then stream the
//   samples on req_ (tuser set on the first sample of a waveform). Each
//   finished column leaves on rsp_ as one transaction; tlast marks the
//   final column.
// Sequence:
//   A sample that does not close a column is captured, then updated. A
//   sample that closes one adds the shared RMS unit: 13 multiply steps,
//   1 saturation check, 30 divide steps and 15 square root steps, plus
//   start, done and hand-off states; a saturated RMS skips divide and
//   square root. That unit does all of this on its one adder.
//   req_tready is high only in the idle state.
// Reset and stall:
//   Reset restores the register defaults and a fresh waveform state, so a
//   stream may start without a start flag. A finished column waits in the
//   output register; the next sample is still taken, and the block holds
//   only when a further column is finished before the first is taken.
// ----------------------------------------------------------------------------
module waveform_peak_rms_decimator (
   input  logic                              clock,
   input  logic                              reset,
   // Sample stream. tdata: [15:0] sample. tuser: [0] start_req.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [wprd_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,
   // Column stream. tdata: [11:0] column, [27:12] min_level,
   // [43:28] max_level, [59:44] rms_level, [63:60] zero.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [wprd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   // Register port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [wprd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [wprd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [wprd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import wprd_pkg::*;

   dec_state_type        state_ff, state_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [COLS_W-1:0]    columns_ff, columns_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                 rsp_last_ff;

   logic                 csr_write;
   logic [TOTAL_W-1:0]   n_eff;
   logic [COLS_W-1:0]    w_req;
   logic [COLS_W-1:0]    w_cap;
   logic [COLS_W-1:0]    w_eff;
   logic                 load_out;
   stats_ctrl_type       ctrl;
   stats_stat_type       stat;
   col_result_type       result;
   rms_req_type          rms_req;
   rms_rsp_type          rms_rsp;

   // Register writes and reads.
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      total_in   = total_ff;
      columns_in = columns_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_TOTAL_SAMPLES: total_in   = csr_pwdata[TOTAL_W-1:0];
            REG_COLUMNS:       columns_in = csr_pwdata[COLS_W-1:0];
            default:           total_in   = total_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_TOTAL_SAMPLES: csr_prdata = CSR_DATA_W'(total_ff);
         REG_COLUMNS:       csr_prdata = CSR_DATA_W'(columns_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // Effective sample and column counts after clamping.
   always_comb begin
      n_eff = (total_ff == '0) ? TOTAL_W'(1) : total_ff;
      w_req = (columns_ff == '0) ? COLS_W'(1) : columns_ff;
      w_cap = (w_req > COLS_W'(MAX_COLUMNS)) ? COLS_W'(MAX_COLUMNS) : w_req;
      w_eff = (TOTAL_W'(w_cap) > n_eff) ? n_eff[COLS_W-1:0] : w_cap;
   end

   // Control of the column statistics follows the state register directly.
   assign ctrl = '{accept: (state_ff == ST_IDLE) && req_tvalid,
                   start:  req_tuser,
                   update: (state_ff == ST_UPDATE)};

   // Sequencer: capture, update, RMS calculation, hand-off to the output.
   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      load_out    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            if (req_tvalid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in    = stat.emit ? ST_CALC : ST_IDLE;
         end
         ST_CALC: begin
            if (rms_rsp.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            load_out = !rsp_valid_ff || rsp_tready;
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rms_req.start = stat.emit;
   assign rms_req.sumsq = stat.sumsq;
   assign rms_req.n     = n_eff;
   assign rms_req.w     = w_eff;

   // Output register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= TOTAL_W'(TOTAL_RESET);
         columns_ff   <= COLS_W'(COLUMNS_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         columns_ff   <= columns_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= {{(RSP_DATA_W - COLUMN_W - 4 * SAMPLE_W + SAMPLE_W){1'b0}},
                         rms_rsp.rms, result.max_level, result.min_level,
                         result.column};
         rsp_last_ff <= result.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   wprd_stats u_stats (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .sample (req_tdata[SAMPLE_W-1:0]),
      .n_eff  (n_eff),
      .w_eff  (w_eff),
      .stat   (stat),
      .result (result)
   );

   wprd_rms_unit u_rms (
      .clock (clock),
      .reset (reset),
      .req   (rms_req),
      .rsp   (rms_rsp)
   );

endmodule
